[rtl/cina_pkg.sv]
package cina_pkg;

	// map geometry
	localparam int IRQ_COUNT  = 256;
	localparam int CELL_BITS  = 4;
	localparam int CELL_COUNT = IRQ_COUNT / CELL_BITS;
	localparam int IDX_W      = $clog2(IRQ_COUNT);
	localparam int CNT_W      = IDX_W + 1;
	localparam int GRP_W      = $clog2(CELL_COUNT);
	localparam int SUB_W      = $clog2(CELL_BITS);

	// field widths
	localparam int NUM_W     = 8;
	localparam int LEN_W     = 9;
	localparam int CFG_W     = 8;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int S_TDATA_W = 24;

	// register word addresses (paddr[PADDR_W-1:2])
	localparam logic [PADDR_W-3:0] REG_WIRED_COUNT = '0;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} cina_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic             shift;
		logic             mark;
		logic             value;
		logic [CNT_W-1:0] lo;
		logic [CNT_W-1:0] hi_x;
	} cina_cell_cmd_t;

endpackage

[rtl/cina_cell.sv]
module cina_cell import cina_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [GRP_W-1:0]     cell_idx,
	input  cina_cell_cmd_t       cmd,
	input  logic [CELL_BITS-1:0] bits_in,
	output logic [CELL_BITS-1:0] bits_out
);

	logic [CELL_BITS-1:0] bits_q;
	logic [CELL_BITS-1:0] marked;

	// range write against this cell's home offsets
	always_comb begin
		logic [CNT_W-1:0] idx;
		marked = bits_q;
		idx    = '0;
		for (int j = 0; j < CELL_BITS; j++) begin
			idx = {1'b0, cell_idx, SUB_W'(j)};
			if (idx >= cmd.lo && idx < cmd.hi_x) begin
				marked[j] = cmd.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (cmd.shift) begin
			bits_q <= bits_in;
		end else if (cmd.mark) begin
			bits_q <= marked;
		end
	end

	assign bits_out = bits_q;

endmodule

[rtl/cina_scan.sv]
module cina_scan import cina_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 step,
	input  logic [GRP_W-1:0]     grp,
	input  logic [CELL_BITS-1:0] bits,
	input  logic [CNT_W-1:0]     len,
	input  logic [CNT_W-1:0]     lim,
	output logic                 found,
	output logic [IDX_W-1:0]     start
);

	logic [CNT_W-1:0] run_q, run_d;
	logic             found_q, found_d;
	logic [IDX_W-1:0] start_q, start_d;

	// free-run count over the group at the head; offsets at or past lim are blocked
	always_comb begin
		logic [CNT_W-1:0] k;
		run_d   = run_q;
		found_d = found_q;
		start_d = start_q;
		k       = '0;
		for (int j = 0; j < CELL_BITS; j++) begin
			k = {1'b0, grp, SUB_W'(j)};
			if (!bits[j] && k < lim) begin
				run_d = CNT_W'(run_d + 1'b1);
			end else begin
				run_d = '0;
			end
			if (!found_d && run_d == len) begin
				found_d = 1'b1;
				start_d = IDX_W'(k + 1'b1 - len);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			found_q <= 1'b0;
			start_q <= '0;
		end else if (clear) begin
			run_q   <= '0;
			found_q <= 1'b0;
			start_q <= '0;
		end else if (step) begin
			run_q   <= run_d;
			found_q <= found_d;
			start_q <= start_d;
		end
	end

	assign found = found_q;
	assign start = start_q;

endmodule

[rtl/contiguous_interrupt_number_allocator.sv]
// Sequence: a free or a refused allocate goes from the input beat straight to apply;
//   an allocate that scans first rotates the whole used map past the head, then applies.
// One item at a time: a new request is taken only while idle;
//   a result beat still waiting holds apply.
// Reset: arst_n clears the used map, the register and the scan and sequencer state at once.
module contiguous_interrupt_number_allocator import cina_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	// request stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // run_start[7:0], run_length[16:8], zero pad
	input  logic [1:0]           s_axis_tuser,  // opcode[0], is_msi[1]
	// result stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [NUM_W-1:0]     m_axis_tdata,  // first_number[7:0]
	output logic                 m_axis_tuser   // granted[0]
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	state_t state_q;

	// ---------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------
	logic [CFG_W-1:0] wired_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_WIRED_COUNT);
	assign prdata  = reg_sel ? PDATA_W'(wired_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wired_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			wired_q <= pwdata[CFG_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Request decode
	// ---------------------------------------------------------------
	logic             in_beat;
	cina_op_t         in_op;
	logic             in_msi;
	logic [CNT_W-1:0] in_start;
	logic [LEN_W-1:0] in_len;
	logic [CNT_W-1:0] base_w;  // first virtual number
	logic [CNT_W-1:0] lim_w;   // offsets below this may be handed out
	logic [CNT_W-1:0] len_c;   // length clamped to the table size
	logic [CNT_W:0]   alloc_end;
	logic             alloc_ok;
	logic             free_ok;
	logic [CNT_W:0]   free_end;
	logic [CNT_W-1:0] free_end_c;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign in_op         = cina_op_t'(s_axis_tuser[0]);
	assign in_msi        = s_axis_tuser[1];
	assign in_start      = CNT_W'(s_axis_tdata[NUM_W-1:0]);
	assign in_len        = s_axis_tdata[NUM_W +: LEN_W];

	assign base_w = CNT_W'(wired_q) + 1'b1;
	assign lim_w  = CNT_W'(IRQ_COUNT) - base_w;
	assign len_c  = (CNT_W'(in_len) > CNT_W'(IRQ_COUNT)) ? CNT_W'(IRQ_COUNT) : CNT_W'(in_len);

	assign alloc_end = {1'b0, base_w} + {1'b0, len_c};
	assign alloc_ok  = in_msi && (len_c != '0) && (alloc_end <= (CNT_W+1)'(IRQ_COUNT));

	// free clears [start - base, min(start + len, table end) - base)
	assign free_ok    = (in_start >= base_w);
	assign free_end   = {1'b0, in_start} + {1'b0, len_c};
	assign free_end_c = (free_end > (CNT_W+1)'(IRQ_COUNT)) ? CNT_W'(IRQ_COUNT)
		: free_end[CNT_W-1:0];

	// per-item registers
	cina_op_t         op_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] free_lo_q;
	logic [CNT_W-1:0] free_hi_q;
	logic             free_ok_q;

	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q      <= in_op;
			len_q     <= len_c;
			free_lo_q <= in_start - base_w;
			free_hi_q <= free_end_c - base_w;
			free_ok_q <= free_ok;
		end
	end

	// ---------------------------------------------------------------
	// Cell row: the map rotates one cell per scan cycle past the head
	// (cell 0); after CELL_COUNT shifts every group is home again.
	// ---------------------------------------------------------------
	logic [GRP_W-1:0]     grp_q;
	logic                 scan_found;
	logic [IDX_W-1:0]     scan_start;
	logic                 apply_go;
	cina_cell_cmd_t       cmd;
	logic [CELL_BITS-1:0] row_bits [CELL_COUNT];

	logic out_valid_q;

	assign apply_go = (state_q == ST_APPLY) && (!out_valid_q || m_axis_tready);

	always_comb begin
		cmd.shift = (state_q == ST_SCAN);
		cmd.value = (op_q == OP_ALLOC);
		if (op_q == OP_FREE) begin
			cmd.mark = apply_go && free_ok_q;
			cmd.lo   = free_lo_q;
			cmd.hi_x = free_hi_q;
		end else begin
			cmd.mark = apply_go && scan_found;
			cmd.lo   = CNT_W'(scan_start);
			cmd.hi_x = CNT_W'(scan_start) + len_q;
		end
	end

	for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
		cina_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (GRP_W'(i)),
			.cmd      (cmd),
			.bits_in  (row_bits[(i + 1) % CELL_COUNT]),
			.bits_out (row_bits[i])
		);
	end

	// head: first-fit run search over the group passing cell 0
	cina_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (in_beat),
		.step   (state_q == ST_SCAN),
		.grp    (grp_q),
		.bits   (row_bits[0]),
		.len    (len_q),
		.lim    (lim_w),
		.found  (scan_found),
		.start  (scan_start)
	);

	// ---------------------------------------------------------------
	// Sequencer and result register
	// ---------------------------------------------------------------
	logic [CNT_W-1:0] first_w;
	logic             out_granted_q;
	logic [NUM_W-1:0] out_first_q;

	assign first_w = base_w + CNT_W'(scan_start);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			grp_q         <= '0;
			out_valid_q   <= 1'b0;
			out_granted_q <= 1'b0;
			out_first_q   <= '0;
		end else begin
			// a new result may replace the one leaving on this edge
			if (apply_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					grp_q <= '0;
					if (in_beat) begin
						// refused allocates skip the scan; found stays clear
						if (in_op == OP_ALLOC && alloc_ok) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_SCAN: begin
					grp_q <= grp_q + 1'b1;
					if (grp_q == GRP_W'(CELL_COUNT - 1)) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (apply_go) begin
						if (op_q == OP_FREE) begin
							out_granted_q <= 1'b1;
							out_first_q   <= '0;
						end else begin
							out_granted_q <= scan_found;
							out_first_q   <= scan_found ? first_w[NUM_W-1:0] : '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_first_q;
	assign m_axis_tuser  = out_granted_q;

endmodule
